@@ sv/lcs_pkg.sv @@
package lcs_pkg;

	localparam int MAX_CHIPS       = 16;
	localparam int PREAMBLE_PULSES = 5;
	localparam int SLOW_PULSES     = 3;

	localparam int CHIP_W = $clog2(MAX_CHIPS);

	typedef logic [2:0] op_t;
	localparam op_t OP_TICK          = 3'd0;
	localparam op_t OP_WRITE_LEDS    = 3'd1;
	localparam op_t OP_WRITE_CURRENT = 3'd2;
	localparam op_t OP_READ_STATUS   = 3'd3;
	localparam op_t OP_SET_ENABLE    = 3'd4;
	localparam op_t OP_LOAD_BYTE     = 3'd5;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_LEDS    = 2'd1,
		KIND_CURRENT = 2'd2,
		KIND_STATUS  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_PRE_LO  = 4'd1,
		PH_PRE_HI  = 4'd2,
		PH_PRE_END = 4'd3,
		PH_DATA_LO = 4'd4,
		PH_DATA_HI = 4'd5,
		PH_LATCH   = 4'd6,
		PH_SLOW_HI = 4'd7,
		PH_SLOW_LO = 4'd8,
		PH_RD_LO   = 4'd9,
		PH_RD_HI   = 4'd10
	} phase_t;

	localparam logic CFG_CHAIN_LENGTH    = 1'b0;
	localparam logic CFG_READ_HALF_TICKS = 1'b1;

	typedef struct packed {
		op_t              op;
		logic [CHIP_W-1:0] index;
		logic [7:0]       byte_value;
		logic             oe_level;
		logic             sdo_level;
	} item_t;

	typedef struct packed {
		logic       clk_level;
		logic       sdi_level;
		logic       oe_n_level;
		logic       latch_level;
		logic       busy_res;
		logic       status_valid;
		logic [3:0] status_index;
		logic [7:0] status_byte;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [CHIP_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

endpackage

@@ sv/lcs_store.sv @@
module lcs_store import lcs_pkg::*; (
	input  logic              clk,
	input  store_wr_t         wr,
	input  logic              rd_en,
	input  logic [CHIP_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem_q [MAX_CHIPS];
	logic [7:0] rd_data_q;

	// The read address is the byte the sequencer will shift next, so the data
	// is ready in the register by the time the low half of the bit comes up.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/lcs_seq.sv @@
module lcs_seq import lcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              step,
	input  item_t             item,
	input  logic [7:0]        store_rd_data,
	output logic [CHIP_W-1:0] store_rd_addr,
	output store_wr_t         store_wr,
	output result_t           result
);

	logic [4:0] chain_q;
	logic [7:0] half_q;

	logic       en_q, saved_q;
	kind_t      kind_q;
	phase_t     phase_q;
	logic [2:0] pulse_q, bit_q;
	logic [3:0] byte_q;
	logic [7:0] hold_q, rx_q;
	logic       clk_q, sdi_q, oe_q, le_q;

	logic       n_en, n_saved;
	kind_t      n_kind;
	phase_t     n_phase;
	logic [2:0] n_pulse, n_bit;
	logic [3:0] n_byte;
	logic [7:0] n_hold, n_rx;
	logic       n_clk, n_sdi, n_oe, n_le;
	logic       busy, sval;

	logic [4:0] len_eff;
	logic [7:0] half_eff;
	logic [8:0] hold_inc;
	logic [4:0] byte_inc;

	always_comb begin
		len_eff = (chain_q > 5'(MAX_CHIPS)) ? 5'(MAX_CHIPS) : chain_q;
	end
	assign half_eff = (half_q == 8'd0) ? 8'd1 : half_q;

	assign store_rd_addr = n_byte;

	always_comb begin
		n_en     = en_q;
		n_saved  = saved_q;
		n_kind   = kind_q;
		n_phase  = phase_q;
		n_pulse  = pulse_q;
		n_bit    = bit_q;
		n_byte   = byte_q;
		n_hold   = hold_q;
		n_rx     = rx_q;
		n_clk    = clk_q;
		n_sdi    = sdi_q;
		n_oe     = oe_q;
		n_le     = le_q;
		busy     = 1'b0;
		sval     = 1'b0;
		hold_inc = {1'b0, hold_q} + 9'd1;
		byte_inc = {1'b0, byte_q} + 5'd1;
		store_wr = '{en: 1'b0, addr: item.index, data: item.byte_value};

		if (phase_q == PH_IDLE) begin
			n_clk = 1'b0;
			n_le  = 1'b0;
			case (item.op)
				OP_SET_ENABLE: begin
					n_en = item.oe_level;
				end
				OP_LOAD_BYTE: begin
					store_wr.en = step;
				end
				OP_WRITE_LEDS, OP_WRITE_CURRENT, OP_READ_STATUS: begin
					n_saved = en_q;
					if (item.op == OP_WRITE_LEDS) begin
						n_kind = KIND_LEDS;
					end else if (item.op == OP_WRITE_CURRENT) begin
						n_kind = KIND_CURRENT;
						n_en   = 1'b1;
					end else begin
						n_kind = KIND_STATUS;
						n_en   = 1'b0;
					end
					n_pulse = 3'd0;
					n_phase = PH_PRE_LO;
				end
				default: ;
			endcase
			n_oe = n_en;
		end

		if (n_phase != PH_IDLE) begin
			busy = 1'b1;
			case (n_phase)
				PH_PRE_LO: begin
					n_clk   = 1'b0;
					n_oe    = (n_pulse == 3'd1) ? 1'b0 : 1'b1;
					n_le    = (n_kind != KIND_LEDS) && (n_pulse == 3'd3);
					n_phase = PH_PRE_HI;
				end
				PH_PRE_HI: begin
					n_clk = 1'b1;
					if ({1'b0, n_pulse} + 4'd1 < 4'(PREAMBLE_PULSES)) begin
						n_pulse = n_pulse + 3'd1;
						n_phase = PH_PRE_LO;
					end else if (n_kind == KIND_STATUS) begin
						n_phase = PH_PRE_END;
					end else begin
						n_bit   = 3'd0;
						n_byte  = 4'd0;
						n_phase = (len_eff == 5'd0) ? PH_LATCH : PH_DATA_LO;
					end
				end
				PH_PRE_END: begin
					n_clk   = 1'b0;
					n_le    = 1'b0;
					n_oe    = n_en;
					n_pulse = 3'd0;
					n_hold  = 8'd0;
					n_phase = PH_SLOW_HI;
				end
				PH_DATA_LO: begin
					n_clk   = 1'b0;
					n_le    = 1'b0;
					n_oe    = n_en;
					n_sdi   = store_rd_data[n_bit];
					n_phase = PH_DATA_HI;
				end
				PH_DATA_HI: begin
					n_clk = 1'b1;
					if (n_bit == 3'd7) begin
						n_bit = 3'd0;
						if (byte_inc >= len_eff) begin
							n_phase = PH_LATCH;
						end else begin
							n_byte  = byte_inc[3:0];
							n_phase = PH_DATA_LO;
						end
					end else begin
						n_bit   = n_bit + 3'd1;
						n_phase = PH_DATA_LO;
					end
				end
				PH_LATCH: begin
					n_clk   = 1'b0;
					n_le    = 1'b1;
					n_oe    = n_en;
					n_en    = n_saved;
					n_phase = PH_IDLE;
				end
				PH_SLOW_HI: begin
					n_clk = 1'b1;
					n_oe  = n_en;
					if (hold_inc >= {1'b0, half_eff}) begin
						n_hold  = 8'd0;
						n_phase = PH_SLOW_LO;
					end else begin
						n_hold = hold_inc[7:0];
					end
				end
				PH_SLOW_LO: begin
					n_clk = 1'b0;
					n_oe  = n_en;
					if (hold_inc >= {1'b0, half_eff}) begin
						n_hold  = 8'd0;
						n_pulse = n_pulse + 3'd1;
						if (n_pulse >= 3'(SLOW_PULSES)) begin
							n_en   = 1'b1;
							n_bit  = 3'd0;
							n_byte = 4'd0;
							if (len_eff == 5'd0) begin
								n_en    = n_saved;
								n_phase = PH_IDLE;
							end else begin
								n_phase = PH_RD_LO;
							end
						end else begin
							n_phase = PH_SLOW_HI;
						end
					end else begin
						n_hold = hold_inc[7:0];
					end
				end
				PH_RD_LO: begin
					n_clk = 1'b0;
					n_oe  = n_en;
					if (n_bit == 3'd0) begin
						n_rx = {7'd0, item.sdo_level};
					end else begin
						n_rx = n_rx | (8'(item.sdo_level) << n_bit);
					end
					sval    = (n_bit == 3'd7);
					n_phase = PH_RD_HI;
				end
				PH_RD_HI: begin
					n_clk = 1'b1;
					n_oe  = n_en;
					if (n_bit == 3'd7) begin
						n_bit = 3'd0;
						if (byte_inc >= len_eff) begin
							n_en    = n_saved;
							n_phase = PH_IDLE;
						end else begin
							n_byte  = byte_inc[3:0];
							n_phase = PH_RD_LO;
						end
					end else begin
						n_bit   = n_bit + 3'd1;
						n_phase = PH_RD_LO;
					end
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end

		result.clk_level    = n_clk;
		result.sdi_level    = n_sdi;
		result.oe_n_level   = n_oe;
		result.latch_level  = n_le;
		result.busy_res     = busy;
		result.status_valid = sval;
		result.status_index = sval ? n_byte : 4'd0;
		result.status_byte  = sval ? n_rx : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= 5'd1;
			half_q  <= 8'd1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_CHAIN_LENGTH) begin
				chain_q <= cfg_data[4:0];
			end else if (cfg_index == CFG_READ_HALF_TICKS) begin
				half_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b1;
			saved_q <= 1'b1;
			kind_q  <= KIND_NONE;
			phase_q <= PH_IDLE;
			pulse_q <= 3'd0;
			bit_q   <= 3'd0;
			byte_q  <= 4'd0;
			hold_q  <= 8'd0;
			rx_q    <= 8'd0;
			clk_q   <= 1'b0;
			sdi_q   <= 1'b0;
			oe_q    <= 1'b1;
			le_q    <= 1'b0;
		end else if (step) begin
			en_q    <= n_en;
			saved_q <= n_saved;
			kind_q  <= n_kind;
			phase_q <= n_phase;
			pulse_q <= n_pulse;
			bit_q   <= n_bit;
			byte_q  <= n_byte;
			hold_q  <= n_hold;
			rx_q    <= n_rx;
			clk_q   <= n_clk;
			sdi_q   <= n_sdi;
			oe_q    <= n_oe;
			le_q    <= n_le;
		end
	end

endmodule

@@ sv/led_driver_chain_sequencer.sv @@
// Channel   Handshake              Contents
// in        in_valid / in_ready    op, index, byte_value, oe_level, sdo_level
// out       out_valid / out_ready  pin levels, busy_res, status_valid/index/byte
// cfg       cfg_we                 cfg_index selects chain_length or read_half_ticks
//
// Each word is one pin tick and yields one result word. A word is registered on
// input, stepped through the sequencer and lands in the output register; one word
// is taken every cycle while the output is not stalled.
// A stalled output holds the sequencer; the input register still takes one word.
// Reset clears all control state; the byte store holds unknown data until loaded.
module led_driver_chain_sequencer import lcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [3:0] index,
	input  logic [7:0] byte_value,
	input  logic       oe_level,
	input  logic       sdo_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       clk_level,
	output logic       sdi_level,
	output logic       oe_n_level,
	output logic       latch_level,
	output logic       busy_res,
	output logic       status_valid,
	output logic [3:0] status_index,
	output logic [7:0] status_byte
);

	logic              valid_s1;
	item_t             item_s1;
	logic              step;
	result_t           result;
	result_t           res_q;
	logic              out_valid_q;
	store_wr_t         store_wr;
	logic [CHIP_W-1:0] store_rd_addr;
	logic [7:0]        store_rd_data;

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{op: op, index: index, byte_value: byte_value,
			             oe_level: oe_level, sdo_level: sdo_level};
		end
	end

	lcs_store u_store (
		.clk     (clk),
		.wr      (store_wr),
		.rd_en   (step),
		.rd_addr (store_rd_addr),
		.rd_data (store_rd_data)
	);

	lcs_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.step          (step),
		.item          (item_s1),
		.store_rd_data (store_rd_data),
		.store_rd_addr (store_rd_addr),
		.store_wr      (store_wr),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign clk_level    = res_q.clk_level;
	assign sdi_level    = res_q.sdi_level;
	assign oe_n_level   = res_q.oe_n_level;
	assign latch_level  = res_q.latch_level;
	assign busy_res     = res_q.busy_res;
	assign status_valid = res_q.status_valid;
	assign status_index = res_q.status_index;
	assign status_byte  = res_q.status_byte;

endmodule
